// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the six-bit text packer RTL.
// Depends on: modules that use these must have clk_i and rst_ni ports.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, masked while reset is asserted
`define STP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising edge, reset included
`define STP_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ===== rtl/stp_pkg.sv =====
// Types, constants and the character code table of the six-bit text packer.
// Depends on: nothing.
package stp_pkg;

  // Result queue geometry
  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResAw    = 2;
  localparam int unsigned ResCw    = 3;

  // Special returns of the character lookup
  localparam logic [6:0] CodeDiscard = 7'd64;
  localparam logic [6:0] CodeBad     = 7'd65;

  // Reset value of the length limit
  localparam logic [8:0] MaxOutReset = 9'd256;
  localparam logic [8:0] BytesSat    = 9'd511;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StBadChar = 2'd1,
    StTooLong = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    status_e    status;
  } result_t;

  // Per-string packing state
  typedef struct packed {
    logic [6:0] pend_bits;
    logic [2:0] pend_cnt;
    logic [8:0] bytes_out;
  } str_state_t;

  // Results caused by one request: 0, 1 or 2 of them
  typedef struct packed {
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } enc_out_t;

  // Result queue status toward the top level
  typedef struct packed {
    logic not_empty;
    logic room_two;
  } fifo_stat_t;

  // ASCII to 6-bit code; CodeDiscard for carriage return, CodeBad otherwise
  function automatic logic [6:0] char_code(input logic [7:0] c);
    logic [6:0] code;
    code = CodeBad;
    if (c >= 8'h61 && c <= 8'h7A) begin
      code = 7'(c - 8'h61) + 7'd1;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      code = 7'(c - 8'h41) + 7'd27;
    end else begin
      case (c)
        8'h20:   code = 7'd53;
        8'h21:   code = 7'd54;
        8'h25:   code = 7'd55;
        8'h2C:   code = 7'd56;
        8'h2E:   code = 7'd57;
        8'h3F:   code = 7'd58;
        8'h3A:   code = 7'd59;
        8'h27:   code = 7'd60;
        8'h28:   code = 7'd61;
        8'h29:   code = 7'd62;
        8'h0A:   code = 7'd63;
        8'h0D:   code = CodeDiscard;
        default: code = CodeBad;
      endcase
    end
    return code;
  endfunction

endpackage

// ===== rtl/stp_encoder.sv =====
// Combinational packing step: one request plus current state gives next state
// and up to two result bytes. Depends on: stp_pkg.
module stp_encoder import stp_pkg::*; (
  input  logic       action_i,
  input  logic [7:0] char_in_i,
  input  logic [8:0] max_out_bytes_i,
  input  str_state_t state_i,
  output str_state_t state_o,
  output enc_out_t   res_o
);

  always_comb begin
    logic [6:0] code;
    logic [6:0] acc;
    logic [3:0] nn;
    logic [12:0] sum;
    logic        full0;
    logic [2:0]  n2;
    logic [12:0] rem;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [9:0]  nxt0;
    logic [9:0]  nxt1;
    logic [8:0]  cnt1;
    logic [8:0]  cnt2;
    status_e     st0;
    status_e     st1;

    code = char_code(char_in_i);

    // append the new code (terminator 0 at end of string) below the valid bits
    acc   = state_i.pend_bits & ~(7'h7F << state_i.pend_cnt);
    nn    = {1'b0, state_i.pend_cnt} + 4'd6;
    sum   = {acc, (action_i ? 6'd0 : code[5:0])};
    full0 = (nn >= 4'd8);
    n2    = full0 ? 3'(nn - 4'd8) : nn[2:0];

    // first full byte, leftover bits, and leftover padded to a byte
    b0  = 8'(sum >> n2);
    rem = sum & ~(13'h1FFF << n2);
    b1  = 8'(rem << (4'd8 - {1'b0, n2}));

    // length check for the first and second emitted byte, saturating count
    nxt0 = {1'b0, state_i.bytes_out} + 10'd1;
    st0  = (nxt0 > {1'b0, max_out_bytes_i}) ? StTooLong : StOk;
    cnt1 = nxt0[9] ? BytesSat : nxt0[8:0];
    nxt1 = {1'b0, cnt1} + 10'd1;
    st1  = (nxt1 > {1'b0, max_out_bytes_i}) ? StTooLong : StOk;
    cnt2 = nxt1[9] ? BytesSat : nxt1[8:0];

    state_o = state_i;
    res_o   = '0;

    if (!action_i) begin
      if (code == CodeDiscard) begin
        // carriage return: nothing changes
        state_o = state_i;
      end else if (code == CodeBad) begin
        res_o.num  = 2'd1;
        res_o.res0 = '{out_byte: 8'd0, last: 1'b1, status: StBadChar};
        state_o    = '0;
      end else begin
        state_o.pend_bits = rem[6:0];
        state_o.pend_cnt  = n2;
        if (full0) begin
          res_o.num         = 2'd1;
          res_o.res0        = '{out_byte: b0, last: 1'b0, status: st0};
          state_o.bytes_out = cnt1;
        end
      end
    end else begin
      // end of string: flush one or two bytes, then start over
      state_o = '0;
      if (full0 && n2 == 3'd0) begin
        res_o.num  = 2'd1;
        res_o.res0 = '{out_byte: b0, last: 1'b1, status: st0};
      end else if (full0) begin
        res_o.num  = 2'd2;
        res_o.res0 = '{out_byte: b0, last: 1'b0, status: st0};
        res_o.res1 = '{out_byte: b1, last: 1'b1, status: st1};
      end else begin
        res_o.num  = 2'd1;
        res_o.res0 = '{out_byte: b1, last: 1'b1, status: st0};
      end
      // cnt2 only matters within this request; the string restarts
      if (cnt2 == '0) begin
        state_o.bytes_out = '0;
      end
    end
  end

endmodule

// ===== rtl/stp_res_fifo.sv =====
// Small result queue: takes up to two results per cycle, gives one per cycle while popped.
// Depends on: stp_pkg, assert_macros.svh.
`include "assert_macros.svh"

module stp_res_fifo import stp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_num_i,
  input  result_t    push0_i,
  input  result_t    push1_i,
  input  logic       pop_i,
  output result_t    head_o,
  output fifo_stat_t stat_o
);

  result_t            mem_q [ResDepth];
  logic [ResAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [ResAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [ResCw-1:0]   cnt_q, cnt_d;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q + ResAw'(push_num_i);
    rd_ptr_d = rd_ptr_q + ResAw'(pop_i);
    cnt_d    = cnt_q + ResCw'(push_num_i) - ResCw'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, two write slots
  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_num_i == 2'd2) begin
      mem_q[wr_ptr_q + ResAw'(1)] <= push1_i;
    end
  end

  assign head_o           = mem_q[rd_ptr_q];
  assign stat_o.not_empty = (cnt_q != '0);
  assign stat_o.room_two  = (cnt_q <= ResCw'(ResDepth - 2));

  `STP_ASSERT_NR(a_cnt_bound, cnt_q <= ResCw'(ResDepth), "result queue count out of range")
  `STP_ASSERT(a_no_underflow, pop_i |-> cnt_q != '0, "pop from empty result queue")
  `STP_ASSERT(a_no_overflow, (push_num_i != 2'd0) |-> stat_o.room_two,
              "push into result queue without room")
  `STP_ASSERT(a_ptr_sync, (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q),
              "empty result queue with unequal pointers")

endmodule

// ===== rtl/six_bit_text_packer.sv =====
// Top level of the six-bit text packer: state registers, limit register,
// encoder and result queue. Depends on: stp_pkg, stp_encoder, stp_res_fifo.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   in      | input     | in_valid_i / in_ready_o | action_i, char_in_i
//   out     | output    | out_valid_o/out_ready_i | out_byte_o, last_o, status_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_wdata_i (max_out_bytes)
//
// One request per cycle while in_ready_o is high; its results enter the 4-entry
// result queue at the accepting edge and leave it one per cycle while popped.
// An end-of-string request may push two bytes at once; in_ready_o drops while
// the queue has fewer than two free entries, so a stalled output fills it.
// Reset clears the packing state and the queue and sets the limit to 256.
`include "assert_macros.svh"

module six_bit_text_packer import stp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic [7:0] char_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic [1:0] status_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [8:0] cfg_wdata_i
);

  str_state_t state_q, state_d;
  str_state_t enc_state;
  enc_out_t   enc_res;
  logic [8:0] max_q;
  logic       in_fire;
  fifo_stat_t fstat;
  result_t    head;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i & in_ready_o;
  assign in_ready_o  = fstat.room_two;

  // limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxOutReset;
    end else if (cfg_valid_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  stp_encoder u_enc (
    .action_i        (action_i),
    .char_in_i       (char_in_i),
    .max_out_bytes_i (max_q),
    .state_i         (state_q),
    .state_o         (enc_state),
    .res_o           (enc_res)
  );

  // packing state advances only on an accepted request
  assign state_d = in_fire ? enc_state : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  stp_res_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_num_i (in_fire ? enc_res.num : 2'd0),
    .push0_i    (enc_res.res0),
    .push1_i    (enc_res.res1),
    .pop_i      (out_valid_o & out_ready_i),
    .head_o     (head),
    .stat_o     (fstat)
  );

  assign out_valid_o = fstat.not_empty;
  assign out_byte_o  = head.out_byte;
  assign last_o      = head.last;
  assign status_o    = head.status;

  `STP_ASSERT(a_end_clears, (in_fire && action_i) |=>
              (state_q.pend_cnt == 3'd0 && state_q.bytes_out == 9'd0),
              "end of string did not clear packing state")
  `STP_ASSERT(a_err_last, (out_valid_o && status_o == StBadChar) |-> last_o,
              "error result without last")
  `STP_ASSERT(a_err_shows, (in_fire && !action_i && char_code(char_in_i) == CodeBad)
              |=> out_valid_o, "error request produced no result")

endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for six_bit_text_packer: directed table, then random strings.
// Depends on: stp_pkg (status codes, result type, limit constants) and the packer RTL.
`timescale 1ns / 100ps

module tb_top import stp_pkg::*; ();

  localparam logic       ActChar   = 1'b0;
  localparam logic       ActEnd    = 1'b1;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam int         SettleCyc = 4;
  localparam int         PhaseReqs = 180;
  localparam int         LongChars = 700;
  localparam int         StallMax  = 3000;
  localparam result_t    NoRes     = '0;

  typedef enum logic [1:0] {RxOpen, RxChoppy, RxStarved} rx_mode_e;

  // One row of the directed table; typed rows carry their bytes by hand
  typedef struct {
    logic       act;
    logic [7:0] ch;
    bit         typed;
    int         n;
    result_t    r0;
    result_t    r1;
  } row_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       action_i    = ActChar;
  logic [7:0] char_in_i   = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic [8:0] cfg_wdata_i = '0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       last_o;
  logic [1:0] status_o;
  logic       cfg_ready_o;

  // Packing state mirrored from the block
  logic [6:0] pend_bits = '0;
  logic [2:0] pend_cnt  = '0;
  logic [8:0] str_bytes = '0;
  logic [8:0] lim       = MaxOutReset;

  result_t  owed_q[$];
  int       fails      = 0;
  int       reqs_sent  = 0;
  int       burst_left = 0;
  bit       valid_up   = 1'b0;
  int       quiet_cyc  = 0;
  rx_mode_e rx_mode    = RxOpen;
  int       rx_span    = 0;

  six_bit_text_packer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .char_in_i  (char_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .last_o     (last_o),
    .status_o   (status_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ASCII to 6-bit code, CodeDiscard for CR, CodeBad for anything else
  function automatic logic [6:0] six_bit_code(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) return 7'(c - 8'h61 + 8'd1);
    if (c >= 8'h41 && c <= 8'h5A) return 7'(c - 8'h41 + 8'd27);
    case (c)
      8'h20:   return 7'd53;
      8'h21:   return 7'd54;
      8'h25:   return 7'd55;
      8'h2C:   return 7'd56;
      8'h2E:   return 7'd57;
      8'h3F:   return 7'd58;
      8'h3A:   return 7'd59;
      8'h27:   return 7'd60;
      8'h28:   return 7'd61;
      8'h29:   return 7'd62;
      8'h0A:   return 7'd63;
      ChCr:    return CodeDiscard;
      default: return CodeBad;
    endcase
  endfunction

  // Index 0..62 picks a codable character, anything above gives CR
  function automatic logic [7:0] text_char(input int unsigned idx);
    if (idx < 26) return 8'h61 + 8'(idx);
    if (idx < 52) return 8'h41 + 8'(idx - 26);
    case (idx)
      52:      return 8'h20;
      53:      return 8'h21;
      54:      return 8'h25;
      55:      return 8'h2C;
      56:      return 8'h2E;
      57:      return 8'h3F;
      58:      return 8'h3A;
      59:      return 8'h27;
      60:      return 8'h28;
      61:      return 8'h29;
      62:      return 8'h0A;
      default: return ChCr;
    endcase
  endfunction

  function automatic result_t mk_res(input logic [7:0] b, input logic l, input status_e s);
    result_t r;
    r.out_byte = b;
    r.last     = l;
    r.status   = s;
    return r;
  endfunction

  // Stamp one outgoing byte with its length status and bump the saturating count
  function automatic result_t tag_byte(input int unsigned bits, input logic l);
    int unsigned nxt;
    nxt = str_bytes + 1;
    str_bytes = (nxt > BytesSat) ? BytesSat : 9'(nxt);
    return mk_res(bits[7:0], l, (nxt > lim) ? StTooLong : StOk);
  endfunction

  function automatic void drop_string();
    pend_bits = '0;
    pend_cnt  = '0;
    str_bytes = '0;
  endfunction

  // Bytes caused by one request; returns how many (0..2)
  function automatic int pack_step(input logic act, input logic [7:0] ch,
                                   output result_t r0, output result_t r1);
    int unsigned acc, nb, code;
    int k;
    r0 = NoRes;
    r1 = NoRes;
    k = 0;
    nb = pend_cnt;
    acc = pend_bits & ((1 << nb) - 1);
    if (act == ActChar) begin
      code = six_bit_code(ch);
      if (code == CodeDiscard) return 0;
      if (code == CodeBad) begin
        drop_string();
        r0 = mk_res(8'h00, 1'b1, StBadChar);
        return 1;
      end
      acc = (acc << 6) | code;
      nb += 6;
      if (nb >= 8) begin
        nb -= 8;
        r0 = tag_byte(acc >> nb, 1'b0);
        k = 1;
        acc &= (1 << nb) - 1;
      end
      pend_bits = acc[6:0];
      pend_cnt  = nb[2:0];
      return k;
    end
    // end of string: terminator code 0, then zero pad to a byte
    acc <<= 6;
    nb += 6;
    if (nb >= 8) begin
      nb -= 8;
      r0 = tag_byte(acc >> nb, nb == 0);
      k = 1;
      acc &= (1 << nb) - 1;
    end
    if (nb > 0) begin
      if (k == 0) r0 = tag_byte(acc << (8 - nb), 1'b1);
      else r1 = tag_byte(acc << (8 - nb), 1'b1);
      k++;
    end
    drop_string();
    return k;
  endfunction

  task automatic lower_valid();
    if (valid_up) begin
      in_valid_i <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  // Drops valid and keeps it low until no owed byte is left
  task automatic drain_owed();
    lower_valid();
    do @(posedge clk_i); while (owed_q.size() != 0);
  endtask

  // Bursts with random gaps, long gap-free stretches, rare full drains
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      lower_valid();
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(0, 8);
    end
    if ($urandom_range(0, 127) == 0) drain_owed();
  endtask

  // Send one request, then queue the bytes it owes
  task automatic issue(input logic act, input logic [7:0] ch, input bit typed,
                       input int t_n, input result_t t0, input result_t t1);
    result_t r0, r1;
    int n;
    in_valid_i <= 1'b1;
    valid_up = 1'b1;
    action_i  <= act;
    char_in_i <= ch;
    do @(posedge clk_i); while (!in_ready_o);
    n = pack_step(act, ch, r0, r1);
    if (typed) begin
      n  = t_n;
      r0 = t0;
      r1 = t1;
    end
    if (n > 0) owed_q.push_back(r0);
    if (n > 1) owed_q.push_back(r1);
    if (!(act == ActChar && ch == ChCr)) reqs_sent++;
    pace_sender();
  endtask

  task automatic write_limit(input logic [8:0] v);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    lim = v;
  endtask

  // Mostly whole strings; the rest single noise bytes and strings cut by a random byte
  task automatic run_phase(input logic [8:0] v);
    int goal, len, roll;
    drain_owed();
    repeat (SettleCyc) @(posedge clk_i);
    write_limit(v);
    if (v == BytesSat) begin
      // long enough to pass the limit and saturate the byte count
      repeat (LongChars) issue(ActChar, text_char($urandom_range(0, 62)), 0, 0, NoRes, NoRes);
      issue(ActEnd, 8'($urandom_range(0, 255)), 0, 0, NoRes, NoRes);
    end
    goal = reqs_sent + PhaseReqs;
    while (reqs_sent < goal) begin
      roll = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 90) : $urandom_range(0, 20);
      if (roll < 80) begin
        repeat (len) issue(ActChar, text_char($urandom_range(0, 64)), 0, 0, NoRes, NoRes);
        issue(ActEnd, 8'($urandom_range(0, 255)), 0, 0, NoRes, NoRes);
      end else if (roll < 90) begin
        issue(ActChar, 8'($urandom_range(0, 255)), 0, 0, NoRes, NoRes);
      end else begin
        repeat (len % 8) issue(ActChar, text_char($urandom_range(0, 62)), 0, 0, NoRes, NoRes);
        issue(ActChar, 8'($urandom_range(0, 255)), 0, 0, NoRes, NoRes);
      end
    end
  endtask

  // Receiver: open, choppy or starved, switching after random spans
  always @(posedge clk_i) begin
    if (rx_span == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_span = $urandom_range(20, 200);
    end else begin
      rx_span--;
    end
    case (rx_mode)
      RxOpen:   out_ready_i <= 1'b1;
      RxChoppy: out_ready_i <= ($urandom_range(0, 3) != 0);
      default:  out_ready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Output check against the oldest owed byte, plus the stall watchdog
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (owed_q.size() == 0) begin
          $error("unexpected byte %02h (last %0b status %0d)", out_byte_o, last_o, status_o);
          fails++;
        end else begin
          want = owed_q.pop_front();
          if (out_byte_o !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_byte_o);
            fails++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last_o);
            fails++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            fails++;
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cyc = 0;
      end else begin
        quiet_cyc++;
      end
      if (quiet_cyc >= StallMax) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    row_t dir_tab [25];
    dir_tab[0]  = '{ActChar, 8'h61, 1'b1, 0, NoRes, NoRes};
    dir_tab[1]  = '{ActEnd,  8'h00, 1'b1, 2, mk_res(8'h04, 1'b0, StOk),
                    mk_res(8'h00, 1'b1, StOk)};
    dir_tab[2]  = '{ActEnd,  8'hFF, 1'b1, 1, mk_res(8'h00, 1'b1, StOk), NoRes};
    dir_tab[3]  = '{ActChar, 8'h7A, 1'b0, 0, NoRes, NoRes};
    dir_tab[4]  = '{ActChar, 8'h5A, 1'b0, 0, NoRes, NoRes};
    dir_tab[5]  = '{ActChar, 8'h0A, 1'b0, 0, NoRes, NoRes};
    dir_tab[6]  = '{ActChar, 8'h41, 1'b0, 0, NoRes, NoRes};
    dir_tab[7]  = '{ActChar, ChCr,  1'b1, 0, NoRes, NoRes};
    dir_tab[8]  = '{ActEnd,  ChCr,  1'b0, 0, NoRes, NoRes};
    dir_tab[9]  = '{ActChar, 8'h00, 1'b1, 1, mk_res(8'h00, 1'b1, StBadChar), NoRes};
    dir_tab[10] = '{ActChar, 8'hFF, 1'b1, 1, mk_res(8'h00, 1'b1, StBadChar), NoRes};
    dir_tab[11] = '{ActChar, 8'h61, 1'b0, 0, NoRes, NoRes};
    dir_tab[12] = '{ActChar, 8'h7F, 1'b1, 1, mk_res(8'h00, 1'b1, StBadChar), NoRes};
    dir_tab[13] = '{ActEnd,  8'h55, 1'b1, 1, mk_res(8'h00, 1'b1, StOk), NoRes};
    dir_tab[14] = '{ActChar, 8'h20, 1'b0, 0, NoRes, NoRes};
    dir_tab[15] = '{ActChar, 8'h21, 1'b0, 0, NoRes, NoRes};
    dir_tab[16] = '{ActChar, 8'h25, 1'b0, 0, NoRes, NoRes};
    dir_tab[17] = '{ActChar, 8'h2C, 1'b0, 0, NoRes, NoRes};
    dir_tab[18] = '{ActChar, 8'h2E, 1'b0, 0, NoRes, NoRes};
    dir_tab[19] = '{ActChar, 8'h3F, 1'b0, 0, NoRes, NoRes};
    dir_tab[20] = '{ActChar, 8'h3A, 1'b0, 0, NoRes, NoRes};
    dir_tab[21] = '{ActChar, 8'h27, 1'b0, 0, NoRes, NoRes};
    dir_tab[22] = '{ActChar, 8'h28, 1'b0, 0, NoRes, NoRes};
    dir_tab[23] = '{ActChar, 8'h29, 1'b0, 0, NoRes, NoRes};
    dir_tab[24] = '{ActEnd,  8'hAA, 1'b0, 0, NoRes, NoRes};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part runs at the reset limit
    foreach (dir_tab[i]) begin
      issue(dir_tab[i].act, dir_tab[i].ch, dir_tab[i].typed, dir_tab[i].n,
            dir_tab[i].r0, dir_tab[i].r1);
    end

    // random part over a sweep of limits, both extremes and zero included
    run_phase(9'd1);
    run_phase(BytesSat);
    run_phase(9'd0);
    run_phase(9'd2);
    run_phase(9'($urandom_range(3, 510)));
    run_phase(9'($urandom_range(3, 510)));
    run_phase(MaxOutReset);

    drain_owed();
    repeat (8) @(posedge clk_i);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
